[hdl/fhp_pkg.sv]
// ----------------------------------------------------------------------------
// fhp_pkg
// Shared types, constants and the coefficient table of the 11-tap FIR
// high-pass filter.
// ----------------------------------------------------------------------------
package fhp_pkg;

  localparam int OUT_WIDTH  = 18;
  localparam int TAP_IDX_W  = 6;
  localparam int COEF_MAX_W = 24;
  localparam int NUM_COEF   = 11;

  // Q1.15 coefficients
  localparam int COEF_Q15 [NUM_COEF] = '{
    20013, -19332, -8975, -2284, 2046, 4131, 4736, 3265, 2462, -1412, -4650
  };

  typedef struct packed {
    logic mul_en;
    logic use_x;
    logic acc_en;
    logic acc_first;
  } mac_ctl_t;

  // coefficient k rescaled to Q1.(cw-1), round half up; zero past the table
  function automatic logic signed [COEF_MAX_W-1:0] fhp_coef(
    input logic [TAP_IDX_W-1:0] k,
    input int                   cw
  );
    int c;
    int r;
    c = (int'(k) < NUM_COEF) ? COEF_Q15[int'(k)] : 0;
    if (cw >= 16) begin
      r = c <<< (cw - 16);
    end else begin
      r = (c + (1 <<< (15 - cw))) >>> (16 - cw);
    end
    return COEF_MAX_W'(r);
  endfunction

endpackage

[hdl/fhp_ring.sv]
// ----------------------------------------------------------------------------
// fhp_ring
// Ring of past samples: one synchronous memory with a registered read port
// and per-entry valid bits so that clear takes effect at once.
// ----------------------------------------------------------------------------
module fhp_ring #(
  parameter int DEPTH = 10,
  parameter int WIDTH = 16,
  parameter int AW    = 4
) (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    clr,
  input  logic [AW-1:0]           rd_addr,
  output logic signed [WIDTH-1:0] rd_data,
  input  logic                    wr_en,
  input  logic [AW-1:0]           wr_addr,
  input  logic signed [WIDTH-1:0] wr_data
);

  logic signed [WIDTH-1:0] mem [DEPTH];
  logic [DEPTH-1:0]        valid;
  logic signed [WIDTH-1:0] data_q;
  logic                    valid_q;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    data_q <= mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (rst || clr) begin
      valid   <= '0;
      valid_q <= 1'b0;
    end else begin
      if (wr_en) begin
        valid[wr_addr] <= 1'b1;
      end
      valid_q <= valid[rd_addr];
    end
  end

  assign rd_data = valid_q ? data_q : '0;

endmodule

[hdl/fhp_mac.sv]
// ----------------------------------------------------------------------------
// fhp_mac
// Shared multiply-accumulate unit: registered product, accumulator, and
// round-to-nearest with saturation to the output width.
// ----------------------------------------------------------------------------
module fhp_mac
  import fhp_pkg::*;
#(
  parameter int SAMPLE_WIDTH = 16,
  parameter int COEF_WIDTH   = 16
) (
  input  logic                           clk,
  input  mac_ctl_t                       ctl,
  input  logic [TAP_IDX_W-1:0]           k,
  input  logic signed [SAMPLE_WIDTH-1:0] x,
  input  logic signed [SAMPLE_WIDTH-1:0] mem_data,
  output logic signed [OUT_WIDTH-1:0]    result
);

  localparam int PROD_W = SAMPLE_WIDTH + COEF_WIDTH;
  localparam int ACC_W  = PROD_W + TAP_IDX_W;
  localparam logic signed [ACC_W-1:0] HALF = ACC_W'(1) <<< (COEF_WIDTH - 2);
  localparam logic signed [ACC_W-1:0] OMAX = ACC_W'((1 <<< (OUT_WIDTH - 1)) - 1);
  localparam logic signed [ACC_W-1:0] OMIN = -ACC_W'(1 <<< (OUT_WIDTH - 1));

  logic signed [COEF_MAX_W-1:0]   coef_full;
  logic signed [COEF_WIDTH-1:0]   coef;
  logic signed [SAMPLE_WIDTH-1:0] operand;
  logic signed [PROD_W-1:0]       prod;
  logic signed [ACC_W-1:0]        acc;
  logic signed [ACC_W-1:0]        rsum;
  logic signed [ACC_W-1:0]        rsh;

  assign coef_full = fhp_coef(k, COEF_WIDTH);
  assign coef      = coef_full[COEF_WIDTH-1:0];
  assign operand   = ctl.use_x ? x : mem_data;

  always_ff @(posedge clk) begin
    if (ctl.mul_en) begin
      prod <= operand * coef;
    end
    if (ctl.acc_en) begin
      if (ctl.acc_first) begin
        acc <= ACC_W'(prod);
      end else begin
        acc <= acc + ACC_W'(prod);
      end
    end
  end

  assign rsum = acc + HALF;
  assign rsh  = rsum >>> (COEF_WIDTH - 1);

  always_comb begin
    priority if (rsh > OMAX) begin
      result = OMAX[OUT_WIDTH-1:0];
    end else if (rsh < OMIN) begin
      result = OMIN[OUT_WIDTH-1:0];
    end else begin
      result = rsh[OUT_WIDTH-1:0];
    end
  end

endmodule

[hdl/fir_highpass_filter_11tap.sv]
// Flow: a new beat is taken only in the idle state, after the previous filter beat has
// finished; the single multiply-accumulate unit walks the sample ring one tap a cycle.
// A clear beat gives no result.
// Reset: synchronous; empties the ring at once, no clearing pass.
// ----------------------------------------------------------------------------
// fir_highpass_filter_11tap
// Direct-form FIR high-pass filter with past samples held in a ring memory
// and a shared multiply-accumulate unit.
// ----------------------------------------------------------------------------
module fir_highpass_filter_11tap
  import fhp_pkg::*;
#(
  parameter int ORDER        = 10,
  parameter int SAMPLE_WIDTH = 16,
  parameter int COEF_WIDTH   = 16
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           in_valid,
  output logic                           in_ready,
  input  logic                           operation,
  input  logic signed [SAMPLE_WIDTH-1:0] sample_mv,
  output logic                           out_valid,
  input  logic                           out_ready,
  output logic signed [OUT_WIDTH-1:0]    filtered_mv
);

  localparam int AW = (ORDER > 1) ? $clog2(ORDER) : 1;
  localparam int KW = $clog2(ORDER + 1);

  typedef enum logic [3:0] {
    ST_IDLE  = 4'b0001,
    ST_RUN   = 4'b0010,
    ST_DRAIN = 4'b0100,
    ST_DONE  = 4'b1000
  } state_t;

  state_t state, state_next;

  logic signed [SAMPLE_WIDTH-1:0] x;
  logic [KW-1:0]                  cnt;
  logic [AW-1:0]                  slot;
  logic [AW-1:0]                  newest;
  logic [AW-1:0]                  newest_next;
  logic                           s1_vld, s1_last, s2_vld, s2_first, s2_last;
  logic [KW-1:0]                  s1_k;
  logic                           acc_done;
  logic                           in_beat, clr, filt;
  logic                           out_free, finish;
  logic signed [SAMPLE_WIDTH-1:0] mem_data;
  logic signed [OUT_WIDTH-1:0]    result;
  mac_ctl_t                       ctl;

  assign in_ready    = (state == ST_IDLE);
  assign in_beat     = in_valid && in_ready;
  assign clr         = in_beat && operation;
  assign filt        = in_beat && !operation;
  assign out_free    = !out_valid || out_ready;
  assign finish      = ((state == ST_DRAIN && acc_done) || state == ST_DONE) && out_free;
  assign newest_next = (newest == '0) ? AW'(ORDER - 1) : newest - 1'b1;

  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (filt) state_next = ST_RUN;
      end
      ST_RUN: begin
        if (cnt == KW'(ORDER)) state_next = ST_DRAIN;
      end
      ST_DRAIN: begin
        if (finish) state_next = ST_IDLE;
        else if (acc_done) state_next = ST_DONE;
      end
      ST_DONE: begin
        if (finish) state_next = ST_IDLE;
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      newest    <= AW'(ORDER - 1);
      s1_vld    <= 1'b0;
      s2_vld    <= 1'b0;
      acc_done  <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      state    <= state_next;
      s1_vld   <= (state == ST_RUN);
      s2_vld   <= s1_vld;
      acc_done <= s2_vld && s2_last;
      if (clr) begin
        newest <= AW'(ORDER - 1);
      end else if (finish) begin
        newest <= newest_next;
      end
      if (finish) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (filt) begin
      x    <= sample_mv;
      cnt  <= '0;
      slot <= newest;
    end else if (state == ST_RUN) begin
      cnt <= cnt + 1'b1;
      if (cnt != '0) begin
        slot <= (slot == AW'(ORDER - 1)) ? '0 : slot + 1'b1;
      end
    end
    s1_k     <= cnt;
    s1_last  <= (cnt == KW'(ORDER));
    s2_first <= (s1_k == '0);
    s2_last  <= s1_last;
    if (finish) begin
      filtered_mv <= result;
    end
  end

  assign ctl.mul_en    = s1_vld;
  assign ctl.use_x     = (s1_k == '0);
  assign ctl.acc_en    = s2_vld;
  assign ctl.acc_first = s2_first;

  fhp_ring #(
    .DEPTH (ORDER),
    .WIDTH (SAMPLE_WIDTH),
    .AW    (AW)
  ) u_ring (
    .clk     (clk),
    .rst     (rst),
    .clr     (clr),
    .rd_addr (slot),
    .rd_data (mem_data),
    .wr_en   (finish),
    .wr_addr (newest_next),
    .wr_data (x)
  );

  fhp_mac #(
    .SAMPLE_WIDTH (SAMPLE_WIDTH),
    .COEF_WIDTH   (COEF_WIDTH)
  ) u_mac (
    .clk      (clk),
    .ctl      (ctl),
    .k        (TAP_IDX_W'(s1_k)),
    .x        (x),
    .mem_data (mem_data),
    .result   (result)
  );

endmodule

[hdl/fhp_checker.sv]
// ----------------------------------------------------------------------------
// fhp_checker
// Port-level checks of the FIR filter's handshake and sequencing.
// ----------------------------------------------------------------------------
module fhp_checker (
  input logic clk,
  input logic rst,
  input logic in_valid,
  input logic in_ready,
  input logic operation,
  input logic out_valid,
  input logic out_ready
);

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid)
    else $error("result beat dropped before it was taken");

  a_rst_empty: assert property (@(posedge clk)
    rst |=> !out_valid)
    else $error("result valid after reset");

  a_clear_silent: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready && operation && !out_valid |=> !out_valid)
    else $error("clear beat produced a result");

  a_busy_after_sample: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready && !operation |=> !in_ready)
    else $error("input taken while a sample is in progress");

endmodule

bind fir_highpass_filter_11tap fhp_checker u_fhp_checker (
  .clk       (clk),
  .rst       (rst),
  .in_valid  (in_valid),
  .in_ready  (in_ready),
  .operation (operation),
  .out_valid (out_valid),
  .out_ready (out_ready)
);
